[hw/rtl/obcp_pkg.sv]
// shared types and constants of the order book crossing profit block
`timescale 1ns / 1ps
package obcp_pkg;
  localparam int LEVELS_DEF = 64;
  localparam int PRICE_W    = 31;
  localparam int QIN_W      = 31;
  localparam int QTY_W      = 48;
  localparam int PROFIT_W   = 63;
  localparam int HALF_W     = 24;

  localparam logic SIDE_SELL = 1'b0;
  localparam logic SIDE_BUY  = 1'b1;

  localparam logic [QTY_W-1:0]    QTY_MAX    = '1;
  localparam logic [PROFIT_W-1:0] PROFIT_MAX = '1;

  typedef struct packed {
    logic               op;
    logic [PRICE_W-1:0] price;
    logic [QIN_W-1:0]   quantity;
  } item_t;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } level_t;
endpackage

[hw/rtl/obcp_if.sv]
// handshake channels for orders and results
`timescale 1ns / 1ps
interface obcp_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [30:0] price;
  logic [30:0] quantity;
  modport source (output valid, op, price, quantity, input ready);
  modport sink (input valid, op, price, quantity, output ready);
endinterface

interface obcp_out_if;
  logic        valid;
  logic        ready;
  logic [62:0] profit;
  logic        table_full;
  modport source (output valid, profit, table_full, input ready);
  modport sink (input valid, profit, table_full, output ready);
endinterface

[hw/rtl/obcp_front.sv]
// front end: accepts orders into a two-entry queue
`timescale 1ns / 1ps
module obcp_front (
  input  logic            clk,
  input  logic            rst,
  obcp_in_if.sink         order,
  output logic            q_valid,
  output obcp_pkg::item_t q_item,
  input  logic            q_ready
);
  obcp_pkg::item_t slots [2];
  logic            wptr;
  logic            rptr;
  logic [1:0]      count;
  logic            push;
  logic            pop;

  assign order.ready = (count != 2'd2);
  assign push = order.valid && order.ready;
  assign pop = q_valid && q_ready;
  assign q_valid = (count != 2'd0);
  assign q_item = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= '{op: order.op, price: order.price, quantity: order.quantity};
    end
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

[hw/rtl/obcp_back.sv]
// back end: price level tables, insert sequencer and merge walk
`timescale 1ns / 1ps
module obcp_back #(
  parameter int LEVELS = obcp_pkg::LEVELS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  obcp_pkg::item_t q_item,
  output logic            q_ready,
  obcp_out_if.source      result
);
  localparam int AW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int CW = $clog2(LEVELS + 1);
  localparam int QW = obcp_pkg::QTY_W;
  localparam int PW = obcp_pkg::PRICE_W;
  localparam int HW = obcp_pkg::HALF_W;
  localparam int SW = QW + PW + 1;

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_SCAN_RD = 13'b0000000000010,
    S_SCAN_EV = 13'b0000000000100,
    S_NEW     = 13'b0000000001000,
    S_SH_RD   = 13'b0000000010000,
    S_SH_WR   = 13'b0000000100000,
    S_M_INIT  = 13'b0000001000000,
    S_M_RD    = 13'b0000010000000,
    S_M_EV    = 13'b0000100000000,
    S_M_M1    = 13'b0001000000000,
    S_M_M2    = 13'b0010000000000,
    S_M_ACC   = 13'b0100000000000,
    S_DONE    = 13'b1000000000000
  } state_t;

  obcp_pkg::level_t buy_mem  [LEVELS];
  obcp_pkg::level_t sell_mem [LEVELS];
  obcp_pkg::level_t buy_rd;
  obcp_pkg::level_t sell_rd;
  obcp_pkg::level_t ins_rd;
  obcp_pkg::level_t wdata;

  state_t            state;
  obcp_pkg::item_t   cur;
  logic [CW-1:0]     n_buy;
  logic [CW-1:0]     n_sell;
  logic [CW-1:0]     n_cur;
  logic [CW-1:0]     pos;
  logic [CW-1:0]     k;
  logic [CW-1:0]     bi;
  logic [CW-1:0]     si;
  logic              full;
  logic [QW-1:0]     brem;
  logic [QW-1:0]     srem;
  logic [QW-1:0]     eb;
  logic [QW-1:0]     es;
  logic              load_b;
  logic              load_s;
  logic [QW-1:0]     t;
  logic [PW-1:0]     diff;
  logic [HW+PW-1:0]  p_lo;
  logic [HW+PW-1:0]  p_hi;
  logic [62:0]       profit;
  logic [SW-1:0]     sum;
  logic [QW:0]       qsum;
  logic [QW-1:0]     qsat;
  logic              rd_en;
  logic [AW-1:0]     buy_ra;
  logic [AW-1:0]     sell_ra;
  logic [AW-1:0]     waddr;
  logic              we;
  logic [CW-1:0]     km1;
  logic [CW-1:0]     bm1;
  logic              out_valid;
  logic [62:0]       out_profit;
  logic              out_full;
  logic              out_load;

  assign q_ready = (state == S_IDLE);
  assign n_cur = cur.op ? n_buy : n_sell;
  assign ins_rd = cur.op ? buy_rd : sell_rd;
  assign km1 = k - CW'(1);
  assign bm1 = bi - CW'(1);
  assign qsum = {1'b0, ins_rd.qty} + (QW + 1)'(cur.quantity);
  assign qsat = qsum[QW] ? obcp_pkg::QTY_MAX : qsum[QW-1:0];
  assign eb = load_b ? buy_rd.qty : brem;
  assign es = load_s ? sell_rd.qty : srem;
  assign sum = SW'(profit) + SW'(p_lo) + (SW'(p_hi) << HW);
  assign out_load = (state == S_DONE) && (!out_valid || result.ready);

  assign result.valid = out_valid;
  assign result.profit = out_profit;
  assign result.table_full = out_full;

  always_comb begin
    rd_en = 1'b0;
    we = 1'b0;
    buy_ra = pos[AW-1:0];
    sell_ra = pos[AW-1:0];
    waddr = pos[AW-1:0];
    wdata = '{price: cur.price, qty: QW'(cur.quantity)};
    case (state)
      S_SCAN_RD: begin
        rd_en = (pos < n_cur);
      end
      S_SCAN_EV: begin
        we = (ins_rd.price == cur.price);
        wdata = '{price: cur.price, qty: qsat};
      end
      S_SH_RD: begin
        rd_en = (k > pos);
        we = !(k > pos);
        buy_ra = km1[AW-1:0];
        sell_ra = km1[AW-1:0];
      end
      S_SH_WR: begin
        we = 1'b1;
        waddr = k[AW-1:0];
        wdata = ins_rd;
      end
      S_M_RD: begin
        rd_en = (bi != '0) && (si < n_sell);
        buy_ra = bm1[AW-1:0];
        sell_ra = si[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      buy_rd <= buy_mem[buy_ra];
      sell_rd <= sell_mem[sell_ra];
    end
    if (we && cur.op == obcp_pkg::SIDE_BUY) buy_mem[waddr] <= wdata;
    if (we && cur.op == obcp_pkg::SIDE_SELL) sell_mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_profit <= profit;
      out_full <= full;
    end
    if (rst) begin
      state <= S_IDLE;
      n_buy <= '0;
      n_sell <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_item;
            pos <= '0;
            full <= 1'b0;
            state <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: begin
          state <= (pos < n_cur) ? S_SCAN_EV : S_NEW;
        end
        S_SCAN_EV: begin
          if (ins_rd.price < cur.price) begin
            pos <= pos + CW'(1);
            state <= S_SCAN_RD;
          end else if (ins_rd.price == cur.price) begin
            state <= S_M_INIT;
          end else begin
            state <= S_NEW;
          end
        end
        S_NEW: begin
          if (n_cur == CW'(LEVELS)) begin
            full <= 1'b1;
            state <= S_M_INIT;
          end else begin
            k <= n_cur;
            state <= S_SH_RD;
          end
        end
        S_SH_RD: begin
          if (k > pos) begin
            state <= S_SH_WR;
          end else begin
            if (cur.op == obcp_pkg::SIDE_BUY) n_buy <= n_buy + CW'(1);
            else n_sell <= n_sell + CW'(1);
            state <= S_M_INIT;
          end
        end
        S_SH_WR: begin
          k <= km1;
          state <= S_SH_RD;
        end
        S_M_INIT: begin
          bi <= n_buy;
          si <= '0;
          load_b <= 1'b1;
          load_s <= 1'b1;
          profit <= '0;
          state <= S_M_RD;
        end
        S_M_RD: begin
          state <= ((bi != '0) && (si < n_sell)) ? S_M_EV : S_DONE;
        end
        S_M_EV: begin
          if (buy_rd.price <= sell_rd.price) begin
            state <= S_DONE;
          end else if (eb == '0) begin
            bi <= bm1;
            load_b <= 1'b1;
            srem <= es;
            load_s <= 1'b0;
            state <= S_M_RD;
          end else if (es == '0) begin
            si <= si + CW'(1);
            load_s <= 1'b1;
            brem <= eb;
            load_b <= 1'b0;
            state <= S_M_RD;
          end else begin
            brem <= eb;
            srem <= es;
            load_b <= 1'b0;
            load_s <= 1'b0;
            t <= (eb < es) ? eb : es;
            diff <= buy_rd.price - sell_rd.price;
            state <= S_M_M1;
          end
        end
        S_M_M1: begin
          p_lo <= t[HW-1:0] * diff;
          state <= S_M_M2;
        end
        S_M_M2: begin
          p_hi <= t[QW-1:HW] * diff;
          state <= S_M_ACC;
        end
        S_M_ACC: begin
          if (sum > SW'(obcp_pkg::PROFIT_MAX)) begin
            profit <= obcp_pkg::PROFIT_MAX;
            state <= S_DONE;
          end else begin
            profit <= sum[62:0];
            brem <= brem - t;
            srem <= srem - t;
            state <= S_M_EV;
          end
        end
        S_DONE: begin
          if (out_load) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

[hw/rtl/order_book_crossing_profit.sv]
// top level of the order book crossing profit block
`timescale 1ns / 1ps
// Orders enter a two-entry queue and are worked one at a time by a sequencer
// over two dual-port price level tables (one read, one write a cycle, read
// data registered). An order is worked in steps: a search over the levels
// below its price, a shift of the levels above it when a new level is
// inserted, then a merge walk over the level steps and matched pairs, each
// pair's profit taken as two partial products and a saturating sum.
// The result register lets the next order start while a result waits.
module order_book_crossing_profit #(
  parameter int LEVELS = obcp_pkg::LEVELS_DEF
) (
  input logic        clk,
  input logic        rst,
  obcp_in_if.sink    order,
  obcp_out_if.source result
);
  logic            q_valid;
  logic            q_ready;
  obcp_pkg::item_t q_item;

  obcp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .order   (order),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_ready (q_ready)
  );

  obcp_back #(
    .LEVELS (LEVELS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_ready (q_ready),
    .result  (result)
  );
endmodule
